FILE: rtl/stb_pkg.sv
package stb_pkg;

    localparam int DUR_W      = 31;
    localparam int RES_W      = 16;
    localparam int IDX_W      = 16;
    localparam int TIU_W      = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = 5;

    // A tick reports at most this many expiries before its closing item.
    localparam int MAX_EXPIRIES = 16;
    localparam int EXP_CNT_W    = 5;

    localparam logic [RES_W-1:0] RES_RESET = 16'd1;
    localparam logic [TIU_W-1:0] TIU_RESET = 5'd16;

    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] KIND_STATUS    = 2'd0;
    localparam logic [1:0] KIND_EXPIRED   = 2'd1;
    localparam logic [1:0] KIND_TICK_DONE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_RES      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMERS_IN_USE = 4'd1;

    typedef struct packed {
        logic [1:0]       operation;
        logic [IDX_W-1:0] timer_index;
        logic [DUR_W-1:0] duration_ms;
        logic             periodic;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [SLOT_OUT_W-1:0] slot_number;
        logic                  accepted;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        logic       load_item;
        logic       div_start;
        logic       arm_commit;
        logic       cancel_commit;
        logic       walk_clear;
        logic       slot_next;
        logic       ram_rd;
        logic       tick_write;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_accepted;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       index_ok;
        logic       res_ok;
        logic       div_done;
        logic       walk_done;
        logic       slot_armed;
        logic       count_zero;
        logic       count_expire;
        logic       report_ok;
        logic       out_free;
    } status_t;

endpackage

FILE: rtl/stb_ram.sv
module stb_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

FILE: rtl/stb_div.sv
module stb_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [stb_pkg::DUR_W-1:0]  dividend,
    input  logic [stb_pkg::RES_W-1:0]  divisor,
    output logic                       done,
    output logic [stb_pkg::DUR_W-1:0]  quotient
);

    logic [stb_pkg::RES_W-1:0]     rem_reg;
    logic [stb_pkg::DUR_W-1:0]     quo_reg;
    logic [stb_pkg::RES_W-1:0]     div_reg;
    logic [stb_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [stb_pkg::RES_W:0]       partial;
    logic [stb_pkg::RES_W:0]       diff;
    logic                          fits;
    logic [stb_pkg::RES_W-1:0]     rem_next;
    logic [stb_pkg::DUR_W-1:0]     quo_next;

    // Restoring division, one quotient bit per cycle, most significant first.
    always_comb
    begin
        partial  = {rem_reg, quo_reg[stb_pkg::DUR_W-1]};
        diff     = partial - {1'b0, div_reg};
        fits     = partial >= {1'b0, div_reg};
        rem_next = fits ? diff[stb_pkg::RES_W-1:0] : partial[stb_pkg::RES_W-1:0];
        quo_next = {quo_reg[stb_pkg::DUR_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= stb_pkg::DIV_CNT_W'(stb_pkg::DUR_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/stb_ctrl.sv
module stb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  stb_pkg::status_t sts,
    output stb_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_STATUS,
        S_TICK_RD,
        S_TICK_EV,
        S_TICK_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   acc_reg;
    logic   acc_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op)
                    stb_pkg::OP_ARM:
                    begin
                        if (sts.index_ok && sts.res_ok)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                        else
                        begin
                            acc_next   = 1'b0;
                            state_next = S_STATUS;
                        end
                    end
                    stb_pkg::OP_CANCEL:
                    begin
                        cmd.cancel_commit = sts.index_ok;
                        acc_next          = sts.index_ok;
                        state_next        = S_STATUS;
                    end
                    stb_pkg::OP_TICK:
                    begin
                        cmd.walk_clear = 1'b1;
                        state_next     = S_TICK_RD;
                    end
                    default:
                    begin
                        acc_next   = 1'b0;
                        state_next = S_STATUS;
                    end
                endcase
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.arm_commit = 1'b1;
                    acc_next       = 1'b1;
                    state_next     = S_STATUS;
                end
            end
            S_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit          = 1'b1;
                    cmd.emit_kind     = stb_pkg::KIND_STATUS;
                    cmd.emit_accepted = acc_reg;
                    state_next        = S_IDLE;
                end
            end
            S_TICK_RD:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_TICK_DONE;
                end
                else if (!sts.slot_armed)
                begin
                    cmd.slot_next = 1'b1;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = S_TICK_EV;
                end
            end
            S_TICK_EV:
            begin
                if (sts.count_zero)
                begin
                    cmd.slot_next = 1'b1;
                    state_next    = S_TICK_RD;
                end
                else if (sts.count_expire && sts.report_ok)
                begin
                    // The write-back waits with the expiry until the output can take it.
                    if (sts.out_free)
                    begin
                        cmd.tick_write = 1'b1;
                        cmd.slot_next  = 1'b1;
                        cmd.emit       = 1'b1;
                        cmd.emit_kind  = stb_pkg::KIND_EXPIRED;
                        state_next     = S_TICK_RD;
                    end
                end
                else
                begin
                    cmd.tick_write = 1'b1;
                    cmd.slot_next  = 1'b1;
                    state_next     = S_TICK_RD;
                end
            end
            S_TICK_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = stb_pkg::KIND_TICK_DONE;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

FILE: rtl/stb_datapath.sv
module stb_datapath #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stb_pkg::in_item_t                   in_item,
    input  stb_pkg::cmd_t                       cmd,
    output stb_pkg::status_t                    sts,
    input  logic                                cfg_valid,
    input  logic [stb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                out_stall,
    output logic                                out_valid,
    output stb_pkg::out_item_t                  out_item
);

    localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SLOT_CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int N_W        = (SLOT_CNT_W > stb_pkg::TIU_W) ? SLOT_CNT_W : stb_pkg::TIU_W;
    localparam int ENTRY_W    = 2 * stb_pkg::DUR_W;

    stb_pkg::in_item_t              item_reg;
    logic [stb_pkg::RES_W-1:0]      res_reg;
    logic [stb_pkg::TIU_W-1:0]      tiu_reg;
    logic [SLOT_CNT_W-1:0]          slot_reg;
    logic [stb_pkg::EXP_CNT_W-1:0]  exp_count_reg;
    logic [NUM_TIMERS-1:0]          armed_reg;
    logic                           out_valid_reg;
    stb_pkg::out_item_t             out_item_reg;

    logic [N_W-1:0]                 n_slots;
    logic [ADDR_W-1:0]              slot_addr;
    logic [ADDR_W-1:0]              item_addr;
    logic [stb_pkg::IDX_W-1:0]      slot_wide;
    logic                           div_done;
    logic [stb_pkg::DUR_W-1:0]      quotient;
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [ENTRY_W-1:0]             wr_data;
    logic [ENTRY_W-1:0]             rd_data;
    logic [stb_pkg::DUR_W-1:0]      cur_count;
    logic [stb_pkg::DUR_W-1:0]      cur_reload;
    logic [stb_pkg::DUR_W-1:0]      count_next;
    logic                           out_free;
    stb_pkg::out_item_t             out_item_next;

    assign n_slots   = (N_W'(tiu_reg) < N_W'(NUM_TIMERS)) ? N_W'(tiu_reg) : N_W'(NUM_TIMERS);
    assign slot_addr = slot_reg[ADDR_W-1:0];
    assign item_addr = item_reg.timer_index[ADDR_W-1:0];
    assign slot_wide = stb_pkg::IDX_W'(slot_reg);

    stb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (item_reg.duration_ms),
        .divisor  (res_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Each entry holds the reload value above the remaining count. An entry is
    // only read while its slot is armed, and arming always writes it first.
    stb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.ram_rd),
        .rd_addr (slot_addr),
        .rd_data (rd_data)
    );

    assign cur_count  = rd_data[stb_pkg::DUR_W-1:0];
    assign cur_reload = rd_data[ENTRY_W-1:stb_pkg::DUR_W];
    assign count_next = (cur_count == stb_pkg::DUR_W'(1)) ? cur_reload
                                                           : cur_count - 1'b1;

    always_comb
    begin
        wr_en   = cmd.arm_commit | cmd.tick_write;
        wr_addr = cmd.arm_commit ? item_addr : slot_addr;
        if (cmd.arm_commit)
        begin
            wr_data = {(item_reg.periodic ? quotient : '0), quotient};
        end
        else
        begin
            wr_data = {cur_reload, count_next};
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_item_next.kind     = cmd.emit_kind;
        out_item_next.accepted = cmd.emit_accepted;
        case (cmd.emit_kind)
            stb_pkg::KIND_STATUS:
            begin
                out_item_next.slot_number = item_reg.timer_index[stb_pkg::SLOT_OUT_W-1:0];
                out_item_next.last        = 1'b1;
            end
            stb_pkg::KIND_EXPIRED:
            begin
                out_item_next.slot_number = slot_wide[stb_pkg::SLOT_OUT_W-1:0];
                out_item_next.last        = 1'b0;
            end
            default:
            begin
                out_item_next.slot_number = '0;
                out_item_next.last        = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        sts.op           = item_reg.operation;
        sts.index_ok     = item_reg.timer_index < stb_pkg::IDX_W'(n_slots);
        sts.res_ok       = res_reg != '0;
        sts.div_done     = div_done;
        sts.walk_done    = N_W'(slot_reg) >= n_slots;
        sts.slot_armed   = armed_reg[slot_addr];
        sts.count_zero   = cur_count == '0;
        sts.count_expire = cur_count == stb_pkg::DUR_W'(1);
        sts.report_ok    = exp_count_reg < stb_pkg::EXP_CNT_W'(stb_pkg::MAX_EXPIRIES);
        sts.out_free     = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg       <= stb_pkg::RES_RESET;
            tiu_reg       <= stb_pkg::TIU_RESET;
            slot_reg      <= '0;
            exp_count_reg <= '0;
            armed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    stb_pkg::REG_TICK_RES:      res_reg <= cfg_data;
                    stb_pkg::REG_TIMERS_IN_USE: tiu_reg <= cfg_data[stb_pkg::TIU_W-1:0];
                    default:                    ;
                endcase
            end
            if (cmd.walk_clear)
            begin
                slot_reg      <= '0;
                exp_count_reg <= '0;
            end
            else
            begin
                if (cmd.slot_next)
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
                if (cmd.emit && (cmd.emit_kind == stb_pkg::KIND_EXPIRED))
                begin
                    exp_count_reg <= exp_count_reg + 1'b1;
                end
            end
            if (cmd.arm_commit)
            begin
                armed_reg[item_addr] <= 1'b1;
            end
            else if (cmd.cancel_commit)
            begin
                armed_reg[item_addr] <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        if (cmd.emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/software_timer_bank.sv
// Bank of NUM_TIMERS countdown timers driven by arm, cancel and tick items.
// Arm loads a slot with duration_ms divided by the tick resolution (and keeps
// that count as a reload value when periodic); cancel disarms a slot; each tick
// counts armed slots in use down and reports an expiry item per slot that
// reaches zero (at most MAX_EXPIRIES per tick), in slot order, followed by a
// closing item. One item is worked on at a time. A valid arm waits on the
// bit-serial divider, which yields one quotient bit per cycle over 31 bits. A
// tick visits each slot within the valid slot count; each armed slot needs a
// registered read from the slot memory and, unless its count is zero, a
// write-back on it. A stalled output adds its wait.
// Configuration registers are written through the cfg port, which is always
// ready, and should be written only while the bank is idle.
module software_timer_bank #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  stb_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output stb_pkg::out_item_t             out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stb_pkg::CFG_DATA_W-1:0] cfg_data
);

    stb_pkg::cmd_t    cmd;
    stb_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    stb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

FILE: rtl/stb_checker.sv
module stb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input stb_pkg::out_item_t out_item
);

    // A result waiting on a stalled output keeps its place and its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled output item changed");

    // Once an item is taken, the bank stalls its input until that item is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was accepted");

    // Only expiry results leave the item open; status and tick closing end it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.last == (out_item.kind != stb_pkg::KIND_EXPIRED)))
        else $error("last flag does not match result kind");

    // Only a command status can report success.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.accepted |-> out_item.kind == stb_pkg::KIND_STATUS)
        else $error("accepted flag set on a tick result");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
